### rtl/bca_pkg.sv
// ----------------------------------------------------------------------------
// bca_pkg
// Shared types and constants of the banded covariance accumulator.
// ----------------------------------------------------------------------------
package bca_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int ADDR_W       = 10;
    localparam int LEN_W        = 11;
    localparam int MAX_BANDS    = 4;
    localparam int BAND_W       = 2;
    localparam int COUNT_W      = 16;
    localparam logic [COUNT_W-1:0] MAX_VECTORS = 16'hFFFF;

    localparam logic [1:0] FUNC_ACC   = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic REG_VECTOR_LENGTH = 1'b0;
    localparam logic REG_BAND_WIDTH    = 1'b1;

    typedef struct packed {
        logic [1:0]        func;
        logic [31:0]       value;
        logic [ADDR_W-1:0] index;
        logic [2:0]        offset;
    } cmd_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [2:0]       bands;
        logic             restart;
    } cfg_t;

    typedef struct packed {
        logic pop;
        logic init_clearing;
    } back_stat_t;

endpackage

### rtl/bca_front.sv
// ----------------------------------------------------------------------------
// bca_front
// Configuration registers, command intake and a two-entry command queue.
// ----------------------------------------------------------------------------
module bca_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          func,
    input  logic [31:0]         element_value,
    input  logic [9:0]          element_index,
    input  logic [2:0]          band_offset,
    input  logic                cfg_valid,
    input  logic                cfg_index,
    input  logic [10:0]         cfg_data,
    output bca_pkg::cmd_t       head,
    output logic                head_valid,
    output bca_pkg::cfg_t       cfg,
    input  bca_pkg::back_stat_t back_stat
);

    bca_pkg::cmd_t    entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic [10:0]      vl_reg;
    logic [2:0]       bw_reg;
    logic             restart_reg;
    logic             accept;
    logic             push;
    logic [10:0]      len;
    logic [10:0]      len_m1;
    logic [2:0]       bands;

    assign busy       = (cnt_reg == 2'd2) || back_stat.init_clearing;
    assign accept     = start && !busy;
    // Unused function codes are dropped here and never reach the queue.
    assign push       = accept && (func != 2'd3);
    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (cnt_reg != 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{func, element_value, element_index, band_offset};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            cnt_reg     <= 2'd0;
            vl_reg      <= 11'd1024;
            bw_reg      <= 3'd2;
            restart_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (back_stat.pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg     <= cnt_reg + {1'b0, push} - {1'b0, back_stat.pop};
            restart_reg <= 1'b0;
            if (cfg_valid)
            begin
                if (cfg_index == bca_pkg::REG_VECTOR_LENGTH)
                begin
                    vl_reg      <= cfg_data;
                    restart_reg <= 1'b1;
                end
                else
                begin
                    bw_reg <= cfg_data[2:0];
                end
            end
        end
    end

    always_comb
    begin
        if (vl_reg == 11'd0)
        begin
            len = 11'd1;
        end
        else if (vl_reg > 11'(bca_pkg::MAX_ELEMENTS))
        begin
            len = 11'(bca_pkg::MAX_ELEMENTS);
        end
        else
        begin
            len = vl_reg;
        end
        len_m1 = len - 11'd1;
        bands  = bw_reg;
        if (bands > 3'(bca_pkg::MAX_BANDS))
        begin
            bands = 3'(bca_pkg::MAX_BANDS);
        end
        if ({8'd0, bands} > len_m1)
        begin
            bands = len_m1[2:0];
        end
    end

    assign cfg = '{len, bands, restart_reg};

endmodule

### rtl/bca_div.sv
// ----------------------------------------------------------------------------
// bca_div
// Signed 64-bit by unsigned 16-bit divider, one quotient bit per cycle,
// truncating toward zero.
// ----------------------------------------------------------------------------
module bca_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] dq_reg;
    logic [16:0] rem_reg;
    logic [15:0] div_reg;
    logic        neg_reg;
    logic [16:0] shifted;
    logic        bit_q;

    assign shifted  = {rem_reg[15:0], dq_reg[63]};
    assign bit_q    = (shifted >= {1'b0, div_reg});
    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? (64'd0 - dq_reg) : dq_reg;

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            dq_reg  <= dividend[63] ? (64'd0 - dividend) : dividend;
            rem_reg <= 17'd0;
            div_reg <= divisor;
            neg_reg <= dividend[63];
        end
        else if (busy_reg)
        begin
            rem_reg <= bit_q ? (shifted - {1'b0, div_reg}) : shifted;
            dq_reg  <= {dq_reg[62:0], bit_q};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### rtl/bca_back.sv
// ----------------------------------------------------------------------------
// bca_back
// Executes queued commands: accumulation into the statistic memories,
// clearing passes and queries through the shared divider.
// ----------------------------------------------------------------------------
module bca_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  bca_pkg::cmd_t       head,
    input  logic                head_valid,
    input  bca_pkg::cfg_t       cfg,
    output bca_pkg::back_stat_t back_stat,
    output logic                result_valid,
    output logic [31:0]         mean_value,
    output logic [62:0]         variance_value,
    output logic [63:0]         covariance_value,
    output logic [15:0]         vector_count,
    output logic [1:0]          status
);

    localparam int AW = bca_pkg::ADDR_W;
    localparam int NB = bca_pkg::MAX_BANDS;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_ACC_WR = 4'd2;
    localparam logic [3:0] S_Q_RD   = 4'd3;
    localparam logic [3:0] S_Q_CAP  = 4'd4;
    localparam logic [3:0] S_MI     = 4'd5;
    localparam logic [3:0] S_SQ     = 4'd6;
    localparam logic [3:0] S_VAR    = 4'd7;
    localparam logic [3:0] S_MJ     = 4'd8;
    localparam logic [3:0] S_CR     = 4'd9;
    localparam logic [3:0] S_COV    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    function automatic logic [64:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        logic [64:0] r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            r = {1'b1, s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
        end
        else
        begin
            r = {1'b0, s[63:0]};
        end
        return r;
    endfunction

    function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        logic [63:0] r;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
        begin
            r = s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        else
        begin
            r = s[63:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] q);
        logic [31:0] r;
        if (!q[63] && (q[62:31] != 32'd0))
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (q[63] && (q[62:31] != 32'hFFFF_FFFF))
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = q[31:0];
        end
        return r;
    endfunction

    logic [3:0]  state_reg;
    logic [3:0]  state_next;
    logic [AW-1:0] clr_cnt_reg;
    logic        init_clr_reg;
    logic [AW-1:0] pos_reg;
    logic [15:0] count_reg;
    logic        sat_reg;
    logic [31:0] recent_reg [NB];

    // Accumulate operands.
    logic [31:0] x_reg;
    logic [AW-1:0] p_reg;
    logic [63:0] sq_prod_reg;
    logic [63:0] cr_prod_reg [NB];

    // Query working registers.
    logic [AW-1:0] qi_reg;
    logic [2:0]  qoff_reg;
    logic        off_ok_reg;
    logic        idx_bad_reg;
    logic [47:0] sum_i_reg;
    logic [47:0] sum_j_reg;
    logic [63:0] sq_i_reg;
    logic [63:0] cross_reg;
    logic [31:0] mean_reg;
    logic [31:0] mj_reg;
    logic [63:0] prod_reg;
    logic [63:0] dvar_reg;
    logic [63:0] dcov_reg;
    logic [62:0] var_reg;
    logic [63:0] cov_reg;
    logic [1:0]  stat_reg;

    logic        div_go_reg;
    logic [63:0] div_a_reg;
    logic [15:0] div_b_reg;
    logic        div_busy;
    logic        div_done;
    logic [63:0] div_q;

    // Memories and their ports.
    logic [47:0] sum_mem [bca_pkg::MAX_ELEMENTS];
    logic [63:0] sq_mem  [bca_pkg::MAX_ELEMENTS];
    logic [47:0] sum_rd;
    logic [63:0] sq_rd;
    logic [63:0] cr_rd   [NB];
    logic [AW-1:0] sum_raddr;
    logic [AW-1:0] cr_raddr [NB];
    logic [AW-1:0] waddr_sum;
    logic        we_sum;
    logic [47:0] wdata_sum;
    logic [63:0] wdata_sq;
    logic [AW-1:0] waddr_cr [NB];
    logic        we_cr    [NB];
    logic [63:0] wdata_cr [NB];

    logic        pop;
    logic [AW-1:0] p_cur;
    logic [48:0] sum_ext;
    logic [64:0] sq_add;
    logic [64:0] cr_add [NB];
    logic        acc_hit;
    logic [AW:0] p_inc;
    logic [15:0] n_m1;
    logic [64:0] dvar_full;
    logic [63:0] var_sum;

    assign n_m1  = count_reg - 16'd1;
    assign p_cur = ({1'b0, pos_reg} >= cfg.len) ? '0 : pos_reg;
    assign p_inc = {1'b0, p_reg} + 1'b1;

    assign sum_ext   = {sum_rd[47], sum_rd} + {{17{x_reg[31]}}, x_reg};
    assign sq_add    = sat_add64(sq_rd, sq_prod_reg);
    assign dvar_full = {div_q[63], div_q} - {prod_reg[63], prod_reg};
    assign var_sum   = dvar_reg + div_q;

    // Command dispatch happens only from the idle state.
    assign pop = (state_reg == S_IDLE) && head_valid;

    always_comb
    begin
        sum_raddr = qi_reg;
        if (state_reg == S_IDLE)
        begin
            sum_raddr = (head.func == bca_pkg::FUNC_ACC) ? p_cur : head.index;
        end
        else if (state_reg == S_Q_RD)
        begin
            sum_raddr = AW'({1'b0, qi_reg} + {{AW-2{1'b0}}, qoff_reg});
        end
    end

    always_comb
    begin
        acc_hit = sq_add[64] || (sum_ext[48] != sum_ext[47]);
        for (int b = 0; b < NB; b++)
        begin
            cr_raddr[b] = (head.func == bca_pkg::FUNC_ACC) ?
                          AW'(p_cur - AW'(b + 1)) : head.index;
            cr_add[b]   = sat_add64(cr_rd[b], cr_prod_reg[b]);
            we_cr[b]    = 1'b0;
            waddr_cr[b] = clr_cnt_reg;
            wdata_cr[b] = 64'd0;
            if (state_reg == S_CLR)
            begin
                we_cr[b] = 1'b1;
            end
            else if (state_reg == S_ACC_WR && (3'(b) < cfg.bands)
                     && ({1'b0, p_reg} >= (AW + 1)'(b + 1)))
            begin
                we_cr[b]    = 1'b1;
                waddr_cr[b] = AW'(p_reg - AW'(b + 1));
                wdata_cr[b] = cr_add[b][63:0];
                if (cr_add[b][64])
                begin
                    acc_hit = 1'b1;
                end
            end
        end
        we_sum    = (state_reg == S_CLR) || (state_reg == S_ACC_WR);
        waddr_sum = (state_reg == S_CLR) ? clr_cnt_reg : p_reg;
        wdata_sum = 48'd0;
        wdata_sq  = 64'd0;
        if (state_reg == S_ACC_WR)
        begin
            if (sum_ext[48] != sum_ext[47])
            begin
                wdata_sum = sum_ext[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
            end
            else
            begin
                wdata_sum = sum_ext[47:0];
            end
            wdata_sq = sq_add[63:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_sum)
        begin
            sum_mem[waddr_sum] <= wdata_sum;
            sq_mem[waddr_sum]  <= wdata_sq;
        end
        sum_rd <= sum_mem[sum_raddr];
        sq_rd  <= sq_mem[sum_raddr];
    end

    for (genvar g = 0; g < NB; g++)
    begin : g_band
        logic [63:0] cr_mem [bca_pkg::MAX_ELEMENTS];

        always_ff @(posedge clk)
        begin
            if (we_cr[g])
            begin
                cr_mem[waddr_cr[g]] <= wdata_cr[g];
            end
            cr_rd[g] <= cr_mem[cr_raddr[g]];
        end
    end

    bca_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (pop && head.func == bca_pkg::FUNC_ACC)
        begin
            x_reg       <= head.value;
            p_reg       <= p_cur;
            sq_prod_reg <= 64'($signed(head.value) * $signed(head.value));
            for (int b = 0; b < NB; b++)
            begin
                cr_prod_reg[b] <= 64'($signed(recent_reg[b]) * $signed(head.value));
            end
        end
        if (pop && head.func == bca_pkg::FUNC_QUERY)
        begin
            qi_reg      <= head.index;
            qoff_reg    <= head.offset;
            idx_bad_reg <= ({1'b0, head.index} >= cfg.len);
            off_ok_reg  <= (head.offset != 3'd0) && (head.offset <= cfg.bands)
                           && (({1'b0, head.index} + {8'd0, head.offset}) < cfg.len);
            mean_reg    <= 32'd0;
            var_reg     <= 63'd0;
            cov_reg     <= 64'd0;
        end
        if (state_reg == S_Q_RD)
        begin
            sum_i_reg <= sum_rd;
            sq_i_reg  <= sq_rd;
            cross_reg <= cr_rd[BAND_SEL(qoff_reg)];
        end
        if (state_reg == S_Q_CAP)
        begin
            sum_j_reg <= sum_rd;
            if (idx_bad_reg)
            begin
                stat_reg <= bca_pkg::ST_RANGE;
            end
            else if (count_reg == 16'd0)
            begin
                stat_reg <= bca_pkg::ST_EMPTY;
            end
            else if (!off_ok_reg)
            begin
                stat_reg <= bca_pkg::ST_RANGE;
            end
            else if (sat_reg)
            begin
                stat_reg <= bca_pkg::ST_SAT;
            end
            else
            begin
                stat_reg <= bca_pkg::ST_OK;
            end
        end
        if (state_reg == S_SQ)
        begin
            prod_reg <= 64'($signed(mean_reg) * $signed(mean_reg));
        end
        if (state_reg == S_CR)
        begin
            prod_reg <= 64'($signed(mean_reg) * $signed(mj_reg));
        end
        if (div_done)
        begin
            case (state_reg)
                S_MI:    mean_reg <= sat32(div_q);
                S_SQ:    dvar_reg <= dvar_full[63:0];
                S_VAR:   var_reg  <= var_sum[63] ? 63'h7FFF_FFFF_FFFF_FFFF : var_sum[62:0];
                S_MJ:    mj_reg   <= sat32(div_q);
                S_CR:    dcov_reg <= sat_sub64(div_q, prod_reg);
                S_COV:   cov_reg  <= sat_add64(dcov_reg, div_q)[63:0];
                default: ;
            endcase
        end
    end

    function automatic logic [bca_pkg::BAND_W-1:0] BAND_SEL(input logic [2:0] off);
        logic [2:0] d;
        d = off - 3'd1;
        return d[bca_pkg::BAND_W-1:0];
    endfunction

    // Sequencer and divider launch.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (clr_cnt_reg == AW'(bca_pkg::MAX_ELEMENTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (head_valid)
                begin
                    case (head.func)
                        bca_pkg::FUNC_ACC:
                        begin
                            if (count_reg < bca_pkg::MAX_VECTORS)
                            begin
                                state_next = S_ACC_WR;
                            end
                        end
                        bca_pkg::FUNC_QUERY: state_next = S_Q_RD;
                        bca_pkg::FUNC_CLEAR: state_next = S_CLR;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_ACC_WR: state_next = S_IDLE;
            S_Q_RD:   state_next = S_Q_CAP;
            S_Q_CAP:
            begin
                state_next = (idx_bad_reg || count_reg == 16'd0) ? S_OUT : S_MI;
            end
            S_MI:
            begin
                if (div_done)
                begin
                    state_next = (count_reg == 16'd1) ? S_OUT : S_SQ;
                end
            end
            S_SQ:
            begin
                if (div_done)
                begin
                    if (!dvar_full[64] && dvar_full[63:0] != 64'd0)
                    begin
                        state_next = S_VAR;
                    end
                    else
                    begin
                        state_next = off_ok_reg ? S_MJ : S_OUT;
                    end
                end
            end
            S_VAR:
            begin
                if (div_done)
                begin
                    state_next = off_ok_reg ? S_MJ : S_OUT;
                end
            end
            S_MJ:    state_next = div_done ? S_CR : S_MJ;
            S_CR:    state_next = div_done ? S_COV : S_CR;
            S_COV:   state_next = div_done ? S_OUT : S_COV;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_next != state_reg)
        begin
            case (state_next)
                S_MI:    div_a_reg <= {{16{sum_i_reg[47]}}, sum_i_reg};
                S_SQ:    div_a_reg <= sq_i_reg;
                S_VAR:   div_a_reg <= dvar_full[63:0];
                S_MJ:    div_a_reg <= {{16{sum_j_reg[47]}}, sum_j_reg};
                S_CR:    div_a_reg <= cross_reg;
                S_COV:   div_a_reg <= sat_sub64(div_q, prod_reg);
                default: div_a_reg <= div_a_reg;
            endcase
            div_b_reg <= (state_next == S_VAR || state_next == S_COV) ? n_m1 : count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            clr_cnt_reg  <= '0;
            init_clr_reg <= 1'b1;
            pos_reg      <= '0;
            count_reg    <= 16'd0;
            sat_reg      <= 1'b0;
            div_go_reg   <= 1'b0;
            for (int b = 0; b < NB; b++)
            begin
                recent_reg[b] <= 32'd0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            div_go_reg <= (state_next != state_reg) &&
                          (state_next == S_MI || state_next == S_SQ || state_next == S_VAR ||
                           state_next == S_MJ || state_next == S_CR || state_next == S_COV);
            if (state_reg == S_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (state_next == S_IDLE)
                begin
                    init_clr_reg <= 1'b0;
                end
            end
            if (pop && head.func == bca_pkg::FUNC_CLEAR)
            begin
                clr_cnt_reg <= '0;
                pos_reg     <= '0;
                count_reg   <= 16'd0;
                sat_reg     <= 1'b0;
                for (int b = 0; b < NB; b++)
                begin
                    recent_reg[b] <= 32'd0;
                end
            end
            if (state_reg == S_ACC_WR)
            begin
                for (int b = NB - 1; b > 0; b--)
                begin
                    recent_reg[b] <= recent_reg[b-1];
                end
                recent_reg[0] <= x_reg;
                if (acc_hit)
                begin
                    sat_reg <= 1'b1;
                end
                if (p_inc >= cfg.len)
                begin
                    pos_reg   <= '0;
                    count_reg <= count_reg + 16'd1;
                end
                else
                begin
                    pos_reg <= p_inc[AW-1:0];
                end
            end
            // A new vector length restarts the vector in progress.
            if (cfg.restart)
            begin
                pos_reg <= '0;
                for (int b = 0; b < NB; b++)
                begin
                    recent_reg[b] <= 32'd0;
                end
            end
        end
    end

    assign back_stat        = '{pop, init_clr_reg};
    assign result_valid     = (state_reg == S_OUT);
    assign mean_value       = mean_reg;
    assign variance_value   = var_reg;
    assign covariance_value = cov_reg;
    assign vector_count     = count_reg;
    assign status           = stat_reg;

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_go_reg |-> !div_busy)
        else $error("divider launched while running");

    a_acc_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC_WR) |-> ($past(state_reg) == S_IDLE))
        else $error("accumulate write without dispatch");

    a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> (state_reg == S_IDLE))
        else $error("result held for more than one cycle");

    a_no_pop_clr: assert property (@(posedge clk) disable iff (!rst_n)
        init_clr_reg |-> (state_reg == S_CLR && !pop))
        else $error("command dispatched during the initial clearing pass");

endmodule

### rtl/banded_covariance_accumulator_core.sv
// ----------------------------------------------------------------------------
// banded_covariance_accumulator_core
// Per-element mean, variance and banded covariance of Q16.16 sample vectors.
// ----------------------------------------------------------------------------
// Commands are taken while busy is low and queued two deep. An accumulate
// reads the stores as it is dispatched from idle, then does the saturating
// add and write back in S_ACC_WR; a clear sweeps all 1024 entries of the
// stores, and the same clearing pass runs after reset, with busy high
// throughout. A query runs up to six divisions through one bit-serial
// divider, and its result appears for one cycle with result_valid; the
// receiver must take it in that cycle. Configuration writes are always
// ready and belong in idle periods.
module banded_covariance_accumulator_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [31:0] element_value,
    input  logic [9:0]  element_index,
    input  logic [2:0]  band_offset,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data,
    output logic        result_valid,
    output logic [31:0] mean_value,
    output logic [62:0] variance_value,
    output logic [63:0] covariance_value,
    output logic [15:0] vector_count,
    output logic [1:0]  status
);

    bca_pkg::cmd_t       head;
    logic                head_valid;
    bca_pkg::cfg_t       cfg;
    bca_pkg::back_stat_t back_stat;

    assign cfg_ready = 1'b1;

    bca_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .element_value (element_value),
        .element_index (element_index),
        .band_offset   (band_offset),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .head          (head),
        .head_valid    (head_valid),
        .cfg           (cfg),
        .back_stat     (back_stat)
    );

    bca_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (head),
        .head_valid       (head_valid),
        .cfg              (cfg),
        .back_stat        (back_stat),
        .result_valid     (result_valid),
        .mean_value       (mean_value),
        .variance_value   (variance_value),
        .covariance_value (covariance_value),
        .vector_count     (vector_count),
        .status           (status)
    );

endmodule

### tb/sv/banded_covariance_accumulator_checker.sv
// ----------------------------------------------------------------------------
// banded_covariance_accumulator_checker
// Watches the command, configuration and result channels of the core. It keeps
// its own copy of the accumulator stores, predicts every query result and
// compares the results field by field, in order.
// ----------------------------------------------------------------------------
module banded_covariance_accumulator_checker
    import bca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  func,
    input  logic [31:0] element_value,
    input  logic [9:0]  element_index,
    input  logic [2:0]  band_offset,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        result_valid,
    input  logic [31:0] mean_value,
    input  logic [62:0] variance_value,
    input  logic [63:0] covariance_value,
    input  logic [15:0] vector_count,
    input  logic [1:0]  status,
    output int          fail_count,
    output int          pending_results,
    output int          checked_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SUM48_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM48_LO = -SUM48_HI - 1;
    localparam longint S64_HI   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_LO   = -S64_HI - 1;

    typedef struct {
        logic [31:0] mean;
        logic [62:0] variance;
        logic [63:0] covariance;
        logic [15:0] count;
        logic [1:0]  stat;
    } stats_t;

    longint element_sum [MAX_ELEMENTS];
    longint element_sq_sum [MAX_ELEMENTS];
    longint lag_product_sum [MAX_BANDS*MAX_ELEMENTS];
    int     last_samples [MAX_BANDS];
    int unsigned cur_pos;
    int unsigned vectors_done;
    bit          sum_clipped;
    int unsigned len_reg;
    int unsigned band_reg;

    stats_t expected_stats[$];
    int     fails;
    int     checked;

    assign fail_count      = fails;
    assign pending_results = expected_stats.size();
    assign checked_results = checked;

    function automatic longint clip_add(longint a, longint b, inout bit hit);
        longint r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63])
        begin
            hit = 1'b1;
            r = a[63] ? S64_LO : S64_HI;
        end
        return r;
    endfunction

    function automatic longint clip_sub(longint a, longint b);
        bit unused_hit;
        unused_hit = 1'b0;
        if (b == S64_LO)
            return (a >= 0) ? S64_HI : a - b;
        return clip_add(a, -b, unused_hit);
    endfunction

    function automatic int unsigned active_len();
        if (len_reg < 1)
            return 1;
        if (len_reg > MAX_ELEMENTS)
            return MAX_ELEMENTS;
        return len_reg;
    endfunction

    function automatic int unsigned active_bands(int unsigned len);
        int unsigned b;
        b = band_reg;
        if (b > MAX_BANDS)
            b = MAX_BANDS;
        if (b > len - 1)
            b = len - 1;
        return b;
    endfunction

    function automatic int element_mean(int unsigned i, longint n);
        longint m;
        m = element_sum[i] / n;
        if (m > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (m < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(m);
    endfunction

    function automatic void wipe_stores();
        foreach (element_sum[k])
        begin
            element_sum[k] = 0;
            element_sq_sum[k] = 0;
        end
        foreach (lag_product_sum[k])
            lag_product_sum[k] = 0;
        foreach (last_samples[k])
            last_samples[k] = 0;
        cur_pos = 0;
        vectors_done = 0;
        sum_clipped = 1'b0;
    endfunction

    function automatic void add_sample(int x);
        int unsigned len;
        int unsigned nb;
        int unsigned p;
        int unsigned k;
        bit hit;
        longint s;
        len = active_len();
        nb = active_bands(len);
        p = cur_pos;
        hit = 1'b0;
        if (vectors_done >= MAX_VECTORS)
            return;
        if (p >= len)
            p = 0;
        s = element_sum[p] + longint'(x);
        if (s > SUM48_HI)
        begin
            s = SUM48_HI;
            hit = 1'b1;
        end
        if (s < SUM48_LO)
        begin
            s = SUM48_LO;
            hit = 1'b1;
        end
        element_sum[p] = s;
        element_sq_sum[p] = clip_add(element_sq_sum[p], longint'(x) * longint'(x), hit);
        for (int unsigned d = 1; d <= nb; d++)
        begin
            if (p >= d)
            begin
                k = (d - 1) * MAX_ELEMENTS + (p - d);
                lag_product_sum[k] = clip_add(lag_product_sum[k],
                    longint'(last_samples[d-1]) * longint'(x), hit);
            end
        end
        for (int d = MAX_BANDS - 1; d > 0; d--)
            last_samples[d] = last_samples[d-1];
        last_samples[0] = x;
        if (hit)
            sum_clipped = 1'b1;
        if (p + 1 >= len)
        begin
            cur_pos = 0;
            vectors_done++;
        end
        else
            cur_pos = p + 1;
    endfunction

    function automatic stats_t query_stats(int unsigned i, int unsigned off);
        stats_t r;
        int unsigned len;
        int unsigned nb;
        longint n;
        int mi;
        int mj;
        bit off_ok;
        bit h;
        longint d;
        longint e;
        longint dd;
        bit [63:0] u;
        longint mean;
        longint cov;
        bit [63:0] var_u;
        logic [1:0] st;
        len = active_len();
        nb = active_bands(len);
        n = vectors_done;
        mean = 0;
        cov = 0;
        var_u = 0;
        st = ST_OK;
        if (i >= len)
            st = ST_RANGE;
        else if (n == 0)
            st = ST_EMPTY;
        else
        begin
            mi = element_mean(i, n);
            off_ok = off >= 1 && off <= nb && i + off < len;
            mean = mi;
            if (n > 1)
            begin
                d = element_sq_sum[i] / n - longint'(mi) * longint'(mi);
                if (d > 0)
                begin
                    u = d + d / (n - 1);
                    var_u = (u > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : u;
                end
                if (off_ok)
                begin
                    h = 1'b0;
                    mj = element_mean(i + off, n);
                    e = lag_product_sum[(off - 1) * MAX_ELEMENTS + i] / n;
                    dd = clip_sub(e, longint'(mi) * longint'(mj));
                    cov = clip_add(dd, dd / (n - 1), h);
                end
            end
            if (!off_ok)
                st = ST_RANGE;
            else if (sum_clipped)
                st = ST_SAT;
        end
        r.mean = mean[31:0];
        r.variance = var_u[62:0];
        r.covariance = cov;
        r.count = vectors_done[15:0];
        r.stat = st;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stats_t want;
        if (!rst_n)
        begin
            wipe_stores();
            len_reg = MAX_ELEMENTS;
            band_reg = 2;
            expected_stats.delete();
            fails = 0;
            checked = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_stats.size() == 0)
                begin
                    $error("result with no query outstanding");
                    fails++;
                end
                else
                begin
                    want = expected_stats.pop_front();
                    checked++;
                    if (mean_value !== want.mean)
                    begin
                        $error("mean_value: expected %0d, got %0d",
                            $signed(want.mean), $signed(mean_value));
                        fails++;
                    end
                    if (variance_value !== want.variance)
                    begin
                        $error("variance_value: expected %0d, got %0d",
                            want.variance, variance_value);
                        fails++;
                    end
                    if (covariance_value !== want.covariance)
                    begin
                        $error("covariance_value: expected %0d, got %0d",
                            $signed(want.covariance), $signed(covariance_value));
                        fails++;
                    end
                    if (vector_count !== want.count)
                    begin
                        $error("vector_count: expected %0d, got %0d",
                            want.count, vector_count);
                        fails++;
                    end
                    if (status !== want.stat)
                    begin
                        $error("status: expected %0d, got %0d", want.stat, status);
                        fails++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_VECTOR_LENGTH)
                begin
                    len_reg = cfg_data;
                    cur_pos = 0;
                    foreach (last_samples[k])
                        last_samples[k] = 0;
                end
                else
                    band_reg = cfg_data[2:0];
            end
            if (start && !busy)
            begin
                case (func)
                    FUNC_ACC:   add_sample(int'(element_value));
                    FUNC_CLEAR: wipe_stores();
                    FUNC_QUERY: expected_stats.push_back(query_stats(element_index, band_offset));
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the banded covariance accumulator with directed and random commands
// under several register settings, with random gaps, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
    import bca_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    // Covers a clear sweep or a query still running once nothing is expected.
    localparam int SETTLE_CYCLES = 1200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  func = FUNC_ACC;
    logic [31:0] element_value = '0;
    logic [9:0]  element_index = '0;
    logic [2:0]  band_offset = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_VECTOR_LENGTH;
    logic [10:0] cfg_data = '0;
    logic        result_valid;
    logic [31:0] mean_value;
    logic [62:0] variance_value;
    logic [63:0] covariance_value;
    logic [15:0] vector_count;
    logic [1:0]  status;
    int          fail_count;
    int          pending_results;
    int          checked_results;
    int          cycle_count = 0;
    int          commands_sent = 0;
    int          settings_used = 0;
    int unsigned cur_len = MAX_ELEMENTS;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    banded_covariance_accumulator_core dut (.*);

    banded_covariance_accumulator_checker checker_i (.*);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return 32'h7FFF_FFFF;
        if (r < 4)
            return 32'h8000_0000;
        if (r < 5)
            return 32'hFFFF_FFFF;
        if (r < 13)
            return $urandom;
        return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
    endfunction

    // One command transfer; the caller lowers start when no command follows.
    task automatic issue(int unsigned gap, logic [1:0] f, logic [31:0] v,
                         logic [9:0] idx, logic [2:0] off);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        func <= f;
        element_value <= v;
        element_index <= idx;
        band_offset <= off;
        do @(posedge clk); while (busy);
        commands_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [10:0] data);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_VECTOR_LENGTH)
            cur_len = (data == 0) ? 1 : (data > MAX_ELEMENTS ? MAX_ELEMENTS : data);
    endtask

    task automatic apply_setting(logic [10:0] len, logic [10:0] bands);
        write_reg(REG_VECTOR_LENGTH, len);
        write_reg(REG_BAND_WIDTH, bands);
        settings_used++;
    endtask

    task automatic random_phase(int items);
        int unsigned r;
        logic [9:0] idx;
        for (int k = 0; k < items; k++)
        begin
            r = $urandom_range(0, 99);
            idx = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, cur_len - 1));
            if (r < 80)
                issue(pick_gap(), FUNC_ACC, pick_sample(), 10'($urandom), 3'($urandom));
            else if (r < 95)
                issue(pick_gap(), FUNC_QUERY, $urandom, idx, 3'($urandom_range(0, 7)));
            else if (r < 97)
                issue(pick_gap(), FUNC_CLEAR, $urandom, 10'($urandom), 3'($urandom));
            else
                issue(pick_gap(), FUNC_UNUSED, $urandom, idx, 3'($urandom));
        end
        start <= 1'b0;
    endtask

    initial
    begin
        logic [10:0] len_pick;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: nothing completed yet, so queries report no samples.
        issue(0, FUNC_ACC, 32'h0001_0000, 10'd0, 3'd0);
        issue(0, FUNC_QUERY, 32'h0, 10'd0, 3'd1);
        issue(0, FUNC_QUERY, 32'h0, 10'd1023, 3'd7);

        apply_setting(11'd3, 11'd2);
        issue(0, FUNC_CLEAR, 32'h0, 10'd0, 3'd0);
        issue(0, FUNC_ACC, 32'h0002_0000, 10'd0, 3'd0);
        issue(0, FUNC_ACC, 32'hFFFF_0000, 10'd0, 3'd0);
        issue(1, FUNC_ACC, 32'h0000_8000, 10'd0, 3'd0);
        issue(0, FUNC_ACC, 32'h0003_0000, 10'd0, 3'd0);
        issue(0, FUNC_ACC, 32'hFFFE_0000, 10'd0, 3'd0);
        issue(0, FUNC_ACC, 32'h0001_0000, 10'd0, 3'd0);
        issue(0, FUNC_QUERY, 32'h0, 10'd0, 3'd1);
        issue(0, FUNC_QUERY, 32'h0, 10'd0, 3'd2);
        issue(0, FUNC_QUERY, 32'h0, 10'd0, 3'd0);
        issue(0, FUNC_QUERY, 32'h0, 10'd0, 3'd3);
        issue(0, FUNC_QUERY, 32'h0, 10'd2, 3'd1);
        issue(0, FUNC_QUERY, 32'h0, 10'd3, 3'd1);
        // Partial vector: stores move while the count stays.
        issue(0, FUNC_ACC, 32'h0010_0000, 10'd0, 3'd0);
        issue(0, FUNC_UNUSED, 32'hFFFF_FFFF, 10'd1, 3'd1);
        issue(0, FUNC_QUERY, 32'h0, 10'd0, 3'd1);
        wait_drained();
        // Extreme samples saturate the square sums.
        issue(0, FUNC_ACC, 32'h8000_0000, 10'd0, 3'd0);
        issue(0, FUNC_ACC, 32'h7FFF_FFFF, 10'd0, 3'd0);
        issue(0, FUNC_ACC, 32'h8000_0000, 10'd0, 3'd0);
        issue(0, FUNC_ACC, 32'h8000_0000, 10'd0, 3'd0);
        issue(0, FUNC_QUERY, 32'h0, 10'd1, 3'd1);
        start <= 1'b0;

        // Counter full: one-element vectors until the count stops.
        apply_setting(11'd1, 11'd7);
        issue(0, FUNC_CLEAR, 32'h0, 10'd0, 3'd0);
        for (int k = 0; k < 65538; k++)
            issue(0, FUNC_ACC, 32'($urandom_range(0, 32'h0004_0000)), 10'd0, 3'd0);
        issue(0, FUNC_QUERY, 32'h0, 10'd0, 3'd1);
        start <= 1'b0;

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: len_pick = 11'd2047;
                1: len_pick = 11'd0;
                2: len_pick = 11'd2;
                default: len_pick = 11'($urandom_range(2, 8));
            endcase
            apply_setting(len_pick, {8'($urandom), 3'($urandom_range(0, 7))});
            if ($urandom_range(0, 9) < 6)
                issue(0, FUNC_CLEAR, $urandom, 10'($urandom), 3'($urandom));
            random_phase((ph == 0) ? 40 : 120);
            if (ph == 5)
                wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d commands over %0d register settings; %0d query results checked.",
            commands_sent, settings_used, checked_results);
        $display("Covered empty, range, saturation, partial vector and full counter cases.");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
